/* rtl/cgc_pkg.sv */
// Shared types, codes and defaults of the copying collector engine.
package cgc_pkg;

  localparam int HALF_WORDS_DEF = 4096;
  localparam int CELL_BITS_DEF  = 32;

  localparam int OP_W    = 3;
  localparam int SIZE_W  = 12;
  localparam int ADDR_W  = 13;
  localparam int INDEX_W = 12;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_ALLOC_REFS = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_INTS = 3'd1;
  localparam logic [OP_W-1:0] OP_START      = 3'd2;
  localparam logic [OP_W-1:0] OP_FORWARD    = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_COLLECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OOM     = 2'd2;

  localparam int FWD_FLAG   = 1;
  localparam int INT_KIND   = 2;
  localparam int META_WORDS = 2;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ALLOC_META, S_ALLOC_ZERO, S_ALLOC_END, S_RD_WAIT,
    S_FWD_BEGIN, S_FWD_META, S_FWD_SIZE, S_CP_RD, S_CP_WR, S_FWD_MARK,
    S_FWD_RET, S_FWD_FAIL, S_SCAN_TOP, S_SCAN_SZ, S_SCAN_MT, S_SCAN_RD,
    S_SCAN_V, S_SCAN_WR, S_FIN_CHECK, S_RESP
  } state_t;

endpackage

/* rtl/copying_gc_engine_top.sv */
// Top level of the semispace copying collector engine with its sequencer.
//
// Usage: the host sends one command per input transfer (in_valid/in_ready)
// and receives exactly one result per command on the output channel
// (out_valid/out_ready). Commands allocate reference or integer arrays,
// start a collection, forward a root, finish a collection, or read and
// write a raw heap cell. The heap lives in one internal RAM of
// 2*HALF_WORDS cells; HALF_WORDS must be a power of two.
// An allocation writes the size and kind words and, for a reference array,
// zeroes each element cell. A root forward that copies moves the object cell
// by cell, since every copy step is a RAM read followed by a RAM write on the
// one shared port pair; a null root, or an object that already carries a
// forwarding mark, is answered without a copy. Finishing a running
// collection walks every copied object, reading its header, then reading,
// forwarding and writing back each reference cell.
// Only one command is worked on at a time; in_ready is high while the
// sequencer is idle, even when a result still waits in the output register.
// A result that finds the output register occupied waits until the
// receiver takes the earlier one, so a stalled receiver stalls the engine.
// Reset clears the pointers, the active half and the collecting flag; the
// heap contents are not cleared and need no clearing pass.
module copying_gc_engine_top #(
  parameter int HALF_WORDS = cgc_pkg::HALF_WORDS_DEF,
  parameter int CELL_BITS  = cgc_pkg::CELL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cgc_pkg::OP_W-1:0]    in_op,
  input  logic [cgc_pkg::SIZE_W-1:0]  in_alloc_size,
  input  logic [cgc_pkg::ADDR_W-1:0]  in_ref_addr,
  input  logic [cgc_pkg::INDEX_W-1:0] in_cell_index,
  input  logic [cgc_pkg::DATA_W-1:0]  in_write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cgc_pkg::STAT_W-1:0]  out_status,
  output logic [cgc_pkg::ADDR_W-1:0]  out_result_addr,
  output logic [cgc_pkg::DATA_W-1:0]  out_read_data
);

  localparam int HEAP = 2 * HALF_WORDS;
  localparam int AW   = $clog2(HEAP);
  localparam int PW   = AW + 1;

  cgc_pkg::state_t state_r, state_nxt;

  // Captured command.
  logic [cgc_pkg::OP_W-1:0]    op_r;
  logic [cgc_pkg::SIZE_W-1:0]  asize_r;
  logic [cgc_pkg::ADDR_W-1:0]  raddr_r;
  logic [cgc_pkg::INDEX_W-1:0] cidx_r;
  logic [cgc_pkg::DATA_W-1:0]  wdata_r;

  // Collector state.
  logic [PW-1:0] ap_r, sp_r;
  logic          half_r, coll_r;

  // Work registers of the forward and scan loops.
  logic [AW-1:0]        obj_r, cell_at_r, fres_r;
  logic [CELL_BITS-1:0] meta_r, fsize_r, ssize_r, val_r;
  logic [PW-1:0]        fi_r, si_r;
  logic                 ret_scan_r;

  // Result being built and the output register.
  logic [cgc_pkg::STAT_W-1:0] status_r;
  logic [cgc_pkg::ADDR_W-1:0] result_r;
  logic [cgc_pkg::DATA_W-1:0] rdata_r;
  logic                       out_valid_r;
  logic [cgc_pkg::STAT_W-1:0] out_status_r;
  logic [cgc_pkg::ADDR_W-1:0] out_result_r;
  logic [cgc_pkg::DATA_W-1:0] out_rdata_r;

  // RAM port signals.
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [CELL_BITS-1:0] mem_wdata, mem_rd;

  logic [PW-1:0] half_end, avail;
  logic          in_xfer, resp_load;
  logic          alloc_short, fwd_bad, scan_bad, fin_short;
  logic [AW-1:0] fwd_r_addr;

  assign in_xfer   = in_valid && in_ready;
  assign resp_load = (state_r == cgc_pkg::S_RESP) && (!out_valid_r || out_ready);
  assign half_end  = half_r ? PW'(HEAP) : PW'(HALF_WORDS);
  assign avail     = half_end - ap_r;

  assign alloc_short = (64'(asize_r) + 64'(cgc_pkg::META_WORDS)) > 64'(avail);
  assign fin_short   = alloc_short;
  assign fwd_bad     = (64'(mem_rd) < 64'(cgc_pkg::META_WORDS)) ||
                       (64'(mem_rd) > 64'(avail));
  assign scan_bad    = (64'(ssize_r) < 64'(cgc_pkg::META_WORDS)) ||
                       (64'(ssize_r) > 64'(ap_r - sp_r));
  assign fwd_r_addr  = AW'(val_r);

  cgc_ram #(.WIDTH(CELL_BITS), .DEPTH(HEAP)) u_heap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rd)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cgc_pkg::S_IDLE: if (in_xfer) state_nxt = cgc_pkg::S_DISPATCH;
      cgc_pkg::S_DISPATCH: begin
        case (op_r) inside
          cgc_pkg::OP_ALLOC_REFS, cgc_pkg::OP_ALLOC_INTS:
            state_nxt = alloc_short ? cgc_pkg::S_RESP : cgc_pkg::S_ALLOC_META;
          cgc_pkg::OP_FORWARD:
            state_nxt = coll_r ? cgc_pkg::S_FWD_BEGIN : cgc_pkg::S_RESP;
          cgc_pkg::OP_FINISH:
            state_nxt = coll_r ? cgc_pkg::S_SCAN_TOP : cgc_pkg::S_FIN_CHECK;
          cgc_pkg::OP_READ: state_nxt = cgc_pkg::S_RD_WAIT;
          default: state_nxt = cgc_pkg::S_RESP;
        endcase
      end
      cgc_pkg::S_ALLOC_META:
        state_nxt = (op_r == cgc_pkg::OP_ALLOC_INTS || asize_r == '0) ?
                    cgc_pkg::S_ALLOC_END : cgc_pkg::S_ALLOC_ZERO;
      cgc_pkg::S_ALLOC_ZERO:
        if (64'(fi_r) + 64'd1 == 64'(asize_r) + 64'(cgc_pkg::META_WORDS))
          state_nxt = cgc_pkg::S_ALLOC_END;
      cgc_pkg::S_ALLOC_END: state_nxt = cgc_pkg::S_RESP;
      cgc_pkg::S_RD_WAIT:   state_nxt = cgc_pkg::S_RESP;
      cgc_pkg::S_FWD_BEGIN:
        state_nxt = (fwd_r_addr == '0) ? cgc_pkg::S_FWD_RET : cgc_pkg::S_FWD_META;
      cgc_pkg::S_FWD_META: state_nxt = cgc_pkg::S_FWD_SIZE;
      cgc_pkg::S_FWD_SIZE: begin
        if (meta_r[0])    state_nxt = cgc_pkg::S_FWD_RET;
        else if (fwd_bad) state_nxt = cgc_pkg::S_FWD_FAIL;
        else              state_nxt = cgc_pkg::S_CP_RD;
      end
      cgc_pkg::S_CP_RD: state_nxt = cgc_pkg::S_CP_WR;
      cgc_pkg::S_CP_WR:
        state_nxt = (64'(fi_r) + 64'd1 == 64'(fsize_r)) ?
                    cgc_pkg::S_FWD_MARK : cgc_pkg::S_CP_RD;
      cgc_pkg::S_FWD_MARK: state_nxt = cgc_pkg::S_FWD_RET;
      cgc_pkg::S_FWD_RET:
        state_nxt = ret_scan_r ? cgc_pkg::S_SCAN_WR : cgc_pkg::S_RESP;
      cgc_pkg::S_FWD_FAIL: state_nxt = cgc_pkg::S_RESP;
      cgc_pkg::S_SCAN_TOP:
        state_nxt = (sp_r >= ap_r) ? cgc_pkg::S_FIN_CHECK : cgc_pkg::S_SCAN_SZ;
      cgc_pkg::S_SCAN_SZ: state_nxt = cgc_pkg::S_SCAN_MT;
      cgc_pkg::S_SCAN_MT: begin
        if (scan_bad)
          state_nxt = cgc_pkg::S_RESP;
        else if (mem_rd[1:0] == 2'b00 && 64'(ssize_r) > 64'(cgc_pkg::META_WORDS))
          state_nxt = cgc_pkg::S_SCAN_RD;
        else
          state_nxt = cgc_pkg::S_SCAN_TOP;
      end
      cgc_pkg::S_SCAN_RD: state_nxt = cgc_pkg::S_SCAN_V;
      cgc_pkg::S_SCAN_V:  state_nxt = cgc_pkg::S_FWD_BEGIN;
      cgc_pkg::S_SCAN_WR:
        state_nxt = (64'(si_r) + 64'd1 == 64'(ssize_r)) ?
                    cgc_pkg::S_SCAN_TOP : cgc_pkg::S_SCAN_RD;
      cgc_pkg::S_FIN_CHECK: state_nxt = cgc_pkg::S_RESP;
      cgc_pkg::S_RESP: if (resp_load) state_nxt = cgc_pkg::S_IDLE;
      default: state_nxt = cgc_pkg::S_IDLE;
    endcase
  end

  // RAM controls and handshake outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    in_ready  = (state_r == cgc_pkg::S_IDLE);
    unique case (state_r)
      cgc_pkg::S_DISPATCH: begin
        if ((op_r == cgc_pkg::OP_ALLOC_REFS || op_r == cgc_pkg::OP_ALLOC_INTS)
            && !alloc_short) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ap_r);
          mem_wdata = CELL_BITS'(64'(asize_r) + 64'(cgc_pkg::META_WORDS));
        end
        if (op_r == cgc_pkg::OP_READ) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(raddr_r + cgc_pkg::ADDR_W'(cidx_r));
        end
        if (op_r == cgc_pkg::OP_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(raddr_r + cgc_pkg::ADDR_W'(cidx_r));
          mem_wdata = CELL_BITS'(wdata_r);
        end
      end
      cgc_pkg::S_ALLOC_META: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ap_r + PW'(1));
        mem_wdata = (op_r == cgc_pkg::OP_ALLOC_INTS) ?
                    CELL_BITS'(cgc_pkg::INT_KIND) : '0;
      end
      cgc_pkg::S_ALLOC_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ap_r + fi_r);
      end
      cgc_pkg::S_FWD_BEGIN: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(fwd_r_addr - AW'(cgc_pkg::META_WORDS) + AW'(1));
      end
      cgc_pkg::S_FWD_META: begin
        mem_re    = 1'b1;
        mem_raddr = obj_r;
      end
      cgc_pkg::S_CP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(obj_r + AW'(fi_r));
      end
      cgc_pkg::S_CP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ap_r + fi_r);
        mem_wdata = mem_rd;
      end
      cgc_pkg::S_FWD_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(obj_r + AW'(1));
        mem_wdata = CELL_BITS'((64'(ap_r) << 1) | 64'(cgc_pkg::FWD_FLAG));
      end
      cgc_pkg::S_SCAN_TOP: begin
        mem_re    = (sp_r < ap_r);
        mem_raddr = AW'(sp_r);
      end
      cgc_pkg::S_SCAN_SZ: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(sp_r + PW'(1));
      end
      cgc_pkg::S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(sp_r + si_r);
      end
      cgc_pkg::S_SCAN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_at_r;
        mem_wdata = CELL_BITS'(fres_r);
      end
      default: ;
    endcase
  end

  // Status chosen when a command is dispatched.
  function automatic logic [cgc_pkg::STAT_W-1:0] STAT_SEL(
    input logic [cgc_pkg::OP_W-1:0] op, input logic short_space);
    logic [cgc_pkg::STAT_W-1:0] s;
    s = cgc_pkg::STAT_OK;
    if ((op == cgc_pkg::OP_ALLOC_REFS || op == cgc_pkg::OP_ALLOC_INTS) && short_space)
      s = cgc_pkg::STAT_COLLECT;
    return s;
  endfunction

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgc_pkg::S_IDLE;
      ap_r        <= '0;
      sp_r        <= '0;
      half_r      <= 1'b0;
      coll_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (resp_load)                out_valid_r <= 1'b1;
      else if (out_ready)           out_valid_r <= 1'b0;
      unique case (state_r)
        cgc_pkg::S_DISPATCH:
          if (op_r == cgc_pkg::OP_START && !coll_r) begin
            half_r <= !half_r;
            ap_r   <= half_r ? '0 : PW'(HALF_WORDS);
            sp_r   <= half_r ? '0 : PW'(HALF_WORDS);
            coll_r <= 1'b1;
          end
        cgc_pkg::S_ALLOC_END:
          ap_r <= ap_r + PW'(64'(asize_r) + 64'(cgc_pkg::META_WORDS));
        cgc_pkg::S_FWD_MARK: ap_r <= ap_r + PW'(fsize_r);
        cgc_pkg::S_FWD_FAIL: if (ret_scan_r) coll_r <= 1'b0;
        cgc_pkg::S_SCAN_TOP: if (sp_r >= ap_r) coll_r <= 1'b0;
        cgc_pkg::S_SCAN_MT: begin
          if (scan_bad)
            coll_r <= 1'b0;
          else if (!(mem_rd[1:0] == 2'b00 &&
                     64'(ssize_r) > 64'(cgc_pkg::META_WORDS)))
            sp_r <= sp_r + PW'(ssize_r);
        end
        cgc_pkg::S_SCAN_WR:
          if (64'(si_r) + 64'd1 == 64'(ssize_r)) sp_r <= sp_r + PW'(ssize_r);
        default: ;
      endcase
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_op;
      asize_r  <= in_alloc_size;
      raddr_r  <= in_ref_addr;
      cidx_r   <= in_cell_index;
      wdata_r  <= in_write_data;
    end
    if (resp_load) begin
      out_status_r <= status_r;
      out_result_r <= result_r;
      out_rdata_r  <= rdata_r;
    end
    unique case (state_r)
      cgc_pkg::S_DISPATCH: begin
        status_r   <= STAT_SEL(op_r, alloc_short);
        result_r   <= (op_r == cgc_pkg::OP_FORWARD && !coll_r) ? raddr_r : '0;
        rdata_r    <= '0;
        fi_r       <= PW'(cgc_pkg::META_WORDS);
        val_r      <= CELL_BITS'(raddr_r);
        ret_scan_r <= 1'b0;
      end
      cgc_pkg::S_ALLOC_ZERO: fi_r <= fi_r + PW'(1);
      cgc_pkg::S_ALLOC_END:
        result_r <= cgc_pkg::ADDR_W'(AW'(ap_r + PW'(cgc_pkg::META_WORDS)));
      cgc_pkg::S_RD_WAIT: rdata_r <= cgc_pkg::DATA_W'(mem_rd);
      cgc_pkg::S_FWD_BEGIN: begin
        obj_r  <= AW'(fwd_r_addr - AW'(cgc_pkg::META_WORDS));
        fres_r <= '0;
      end
      cgc_pkg::S_FWD_META: meta_r <= mem_rd;
      cgc_pkg::S_FWD_SIZE: begin
        fsize_r <= mem_rd;
        fi_r    <= '0;
        fres_r  <= AW'((meta_r >> 1) + CELL_BITS'(cgc_pkg::META_WORDS));
      end
      cgc_pkg::S_CP_WR:    fi_r <= fi_r + PW'(1);
      cgc_pkg::S_FWD_MARK: fres_r <= AW'(ap_r + PW'(cgc_pkg::META_WORDS));
      cgc_pkg::S_FWD_RET:  if (!ret_scan_r) result_r <= cgc_pkg::ADDR_W'(fres_r);
      cgc_pkg::S_FWD_FAIL: begin
        status_r <= cgc_pkg::STAT_OOM;
        result_r <= '0;
      end
      cgc_pkg::S_SCAN_SZ: ssize_r <= mem_rd;
      cgc_pkg::S_SCAN_MT: begin
        si_r <= PW'(cgc_pkg::META_WORDS);
        if (scan_bad) status_r <= cgc_pkg::STAT_OOM;
      end
      cgc_pkg::S_SCAN_RD: cell_at_r <= AW'(sp_r + si_r);
      cgc_pkg::S_SCAN_V: begin
        val_r      <= mem_rd;
        ret_scan_r <= 1'b1;
      end
      cgc_pkg::S_SCAN_WR:   si_r <= si_r + PW'(1);
      cgc_pkg::S_FIN_CHECK: if (fin_short) status_r <= cgc_pkg::STAT_OOM;
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_result_r;
  assign out_read_data   = out_rdata_r;

`ifndef SYNTH
  a_ap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ap_r <= PW'(HEAP))
    else $error("allocation pointer ran past the heap");
  a_scan_behind: assert property (@(posedge clk) disable iff (!rst_n)
    coll_r |-> sp_r <= ap_r)
    else $error("scan pointer passed the allocation pointer");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("RAM read and write issued in the same cycle");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("engine took a command while busy");
`endif

endmodule

/* rtl/cgc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* verif/copying_gc_engine_top_tb.sv */
// Self-checking testbench for the copying collector engine top level.
module copying_gc_engine_top_tb;

  // The 3-bit op field also allows code 7, which the engine answers as a no-op.
  localparam logic [cgc_pkg::OP_W-1:0] OP_NOP = 3'd7;
  localparam int HEAP_CELLS = 2 * cgc_pkg::HALF_WORDS_DEF;
  localparam int NUM_CMDS   = 500;
  localparam int QUIET_TAIL = 60;
  localparam int LIMIT      = 20000000;

  typedef struct packed {
    logic [cgc_pkg::OP_W-1:0]    op;
    logic [cgc_pkg::SIZE_W-1:0]  alloc_size;
    logic [cgc_pkg::ADDR_W-1:0]  ref_addr;
    logic [cgc_pkg::INDEX_W-1:0] cell_index;
    logic [cgc_pkg::DATA_W-1:0]  write_data;
  } cmd_t;

  typedef struct packed {
    logic [cgc_pkg::OP_W-1:0]   op;
    logic [cgc_pkg::STAT_W-1:0] status;
    logic [cgc_pkg::ADDR_W-1:0] result_addr;
    logic [cgc_pkg::DATA_W-1:0] read_data;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [cgc_pkg::OP_W-1:0]    in_op = '0;
  logic [cgc_pkg::SIZE_W-1:0]  in_alloc_size = '0;
  logic [cgc_pkg::ADDR_W-1:0]  in_ref_addr = '0;
  logic [cgc_pkg::INDEX_W-1:0] in_cell_index = '0;
  logic [cgc_pkg::DATA_W-1:0]  in_write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [cgc_pkg::STAT_W-1:0] out_status;
  logic [cgc_pkg::ADDR_W-1:0] out_result_addr;
  logic [cgc_pkg::DATA_W-1:0] out_read_data;

  copying_gc_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_alloc_size(in_alloc_size), .in_ref_addr(in_ref_addr),
    .in_cell_index(in_cell_index), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_result_addr(out_result_addr),
    .out_read_data(out_read_data)
  );

  always #5 clk = ~clk;

  // Commands waiting to be offered, and the replies the engine owes us, in order.
  cmd_t   pending_cmds[$];
  reply_t owed_replies[$];

  int errors = 0;
  int replies_seen = 0;
  int cycles = 0;
  int total_cmds = 0;
  int op_count[8];
  int need_gc_seen = 0;
  int oom_seen = 0;
  int gc_cycles_run = 0;

  // ---------------------------------------------------------------------------
  // Collector shadow state. Every cell carries a "has been written" bit so that
  // stimulus never makes the engine read a cell whose content is undefined.
  // ---------------------------------------------------------------------------
  logic [31:0] heap_cells [HEAP_CELLS];
  bit          heap_known [HEAP_CELLS];
  int unsigned bump_at, scan_at;
  bit          upper_half_active, gc_running;
  bit          touched_unknown;

  logic [31:0] heap_cells_bak [HEAP_CELLS];
  bit          heap_known_bak [HEAP_CELLS];
  int unsigned bump_at_bak, scan_at_bak;
  bit          upper_bak, gc_bak;

  // User addresses of objects believed live, with their kind and user size.
  int unsigned live_objs[$];
  bit          live_is_int[$];
  int unsigned live_len[$];
  int unsigned from_space_objs[$];

  function automatic int unsigned cell_at(longint unsigned a);
    return int'(a % HEAP_CELLS);
  endfunction

  function automatic longint unsigned space_end();
    return (longint'(upper_half_active) + 1) * cgc_pkg::HALF_WORDS_DEF;
  endfunction

  function automatic logic [31:0] peek(int unsigned a);
    if (!heap_known[a]) touched_unknown = 1'b1;
    return heap_cells[a];
  endfunction

  function automatic void poke(int unsigned a, logic [31:0] v);
    heap_cells[a] = v;
    heap_known[a] = 1'b1;
  endfunction

  // Copies one object into to-space unless it already carries a forwarding mark.
  function automatic bit evacuate(int unsigned obj, output int unsigned moved_to);
    int unsigned meta_at;
    logic [31:0] meta, len;
    longint unsigned i;
    meta_at = cell_at(longint'(obj) + 1);
    meta = peek(meta_at);
    moved_to = 0;
    if (meta[0]) begin
      moved_to = cell_at(meta >> 1);
      return 1'b1;
    end
    len = peek(obj);
    if (len < cgc_pkg::META_WORDS || longint'(len) > space_end() - bump_at) return 1'b0;
    for (i = 0; i < len; i++)
      poke(cell_at(bump_at + i), peek(cell_at(obj + i)));
    poke(meta_at, {bump_at[30:0], 1'b1});
    moved_to = bump_at;
    bump_at += len;
    return 1'b1;
  endfunction

  function automatic bit chase_ref(logic [31:0] v, output logic [31:0] nv);
    int unsigned r, moved;
    r = cell_at(v);
    nv = 0;
    if (r == 0) return 1'b1;
    if (!evacuate(cell_at(longint'(r) + HEAP_CELLS - cgc_pkg::META_WORDS), moved))
      return 1'b0;
    nv = cell_at(longint'(moved) + cgc_pkg::META_WORDS);
    return 1'b1;
  endfunction

  // Cheney scan over everything copied so far; bails out on a bad read or size.
  function automatic bit cheney_scan();
    logic [31:0] len, meta, nv;
    longint unsigned i;
    int unsigned at;
    while (scan_at < bump_at) begin
      len = peek(scan_at);
      meta = peek(cell_at(longint'(scan_at) + 1));
      if (touched_unknown) return 1'b0;
      if (len < cgc_pkg::META_WORDS || len > bump_at - scan_at) return 1'b0;
      if (meta[1:0] == 2'b00) begin
        for (i = cgc_pkg::META_WORDS; i < len; i++) begin
          at = cell_at(scan_at + i);
          if (!chase_ref(peek(at), nv) || touched_unknown) return 1'b0;
          poke(at, nv);
        end
      end
      scan_at += len;
    end
    return 1'b1;
  endfunction

  function automatic reply_t predict_reply(cmd_t c);
    reply_t r;
    longint unsigned need;
    int unsigned base;
    logic [31:0] fwd;
    bit ok;
    r = '0;
    r.op = c.op;
    case (c.op) inside
      cgc_pkg::OP_ALLOC_REFS, cgc_pkg::OP_ALLOC_INTS: begin
        need = longint'(c.alloc_size) + cgc_pkg::META_WORDS;
        if (need > space_end() - bump_at) begin
          r.status = cgc_pkg::STAT_COLLECT;
        end else begin
          base = bump_at;
          poke(base, need);
          poke(base + 1, (c.op == cgc_pkg::OP_ALLOC_INTS) ? cgc_pkg::INT_KIND : 0);
          if (c.op == cgc_pkg::OP_ALLOC_REFS)
            for (int unsigned i = cgc_pkg::META_WORDS; i < need; i++) poke(base + i, 0);
          bump_at += need;
          r.result_addr = cell_at(longint'(base) + cgc_pkg::META_WORDS);
        end
      end
      cgc_pkg::OP_START: begin
        if (!gc_running) begin
          upper_half_active = ~upper_half_active;
          bump_at = upper_half_active ? cgc_pkg::HALF_WORDS_DEF : 0;
          scan_at = bump_at;
          gc_running = 1'b1;
        end
      end
      cgc_pkg::OP_FORWARD: begin
        if (!gc_running) begin
          r.result_addr = c.ref_addr;
        end else if (!chase_ref(c.ref_addr, fwd)) begin
          r.status = cgc_pkg::STAT_OOM;
        end else begin
          r.result_addr = fwd[cgc_pkg::ADDR_W-1:0];
        end
      end
      cgc_pkg::OP_FINISH: begin
        ok = 1'b1;
        if (gc_running) begin
          ok = cheney_scan();
          gc_running = 1'b0;
        end
        if (!ok ||
            longint'(c.alloc_size) + cgc_pkg::META_WORDS > space_end() - bump_at)
          r.status = cgc_pkg::STAT_OOM;
      end
      cgc_pkg::OP_READ:
        r.read_data = peek(cell_at(longint'(c.ref_addr) + c.cell_index));
      cgc_pkg::OP_WRITE:
        poke(cell_at(longint'(c.ref_addr) + c.cell_index), c.write_data);
      default: ;
    endcase
    return r;
  endfunction

  // Predicts a candidate command on the shadow state. If it would make the engine
  // read an undefined cell the state is rolled back and the command is dropped.
  task automatic offer_cmd(input cmd_t c, output bit taken);
    reply_t r;
    heap_cells_bak = heap_cells;
    heap_known_bak = heap_known;
    bump_at_bak = bump_at;
    scan_at_bak = scan_at;
    upper_bak = upper_half_active;
    gc_bak = gc_running;
    touched_unknown = 1'b0;
    r = predict_reply(c);
    taken = !touched_unknown;
    if (!taken) begin
      heap_cells = heap_cells_bak;
      heap_known = heap_known_bak;
      bump_at = bump_at_bak;
      scan_at = scan_at_bak;
      upper_half_active = upper_bak;
      gc_running = gc_bak;
      return;
    end
    pending_cmds.push_back(c);
    owed_replies.push_back(r);
    total_cmds++;
    op_count[c.op]++;
    if (r.status == cgc_pkg::STAT_COLLECT) need_gc_seen++;
    if (r.status == cgc_pkg::STAT_OOM) oom_seen++;
    // Keep the list of objects we can point at in step with the heap.
    if ((c.op == cgc_pkg::OP_ALLOC_REFS || c.op == cgc_pkg::OP_ALLOC_INTS) &&
        r.status == cgc_pkg::STAT_OK && r.result_addr != 0) begin
      live_objs.push_back(r.result_addr);
      live_is_int.push_back(c.op == cgc_pkg::OP_ALLOC_INTS);
      live_len.push_back(c.alloc_size);
    end else if (c.op == cgc_pkg::OP_START && !gc_bak) begin
      gc_cycles_run++;
      from_space_objs = live_objs;
      live_objs = {};
      live_is_int = {};
      live_len = {};
    end else if (c.op == cgc_pkg::OP_FORWARD && gc_bak && r.status == cgc_pkg::STAT_OK &&
                 r.result_addr != 0) begin
      live_objs.push_back(r.result_addr);
      live_is_int.push_back(heap_cells[cell_at(longint'(r.result_addr) + HEAP_CELLS - 1)][1]);
      live_len.push_back(heap_cells[cell_at(longint'(r.result_addr) + HEAP_CELLS - 2)] - 2);
    end
  endtask

  function automatic cmd_t mk(logic [cgc_pkg::OP_W-1:0] op, int unsigned sz,
                              int unsigned ra, int unsigned ci, logic [31:0] wd);
    cmd_t c;
    c.op = op;
    c.alloc_size = sz;
    c.ref_addr = ra;
    c.cell_index = ci;
    c.write_data = wd;
    return c;
  endfunction

  function automatic int unsigned pick_alloc_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(0, 24);
    if (p < 95) return $urandom_range(25, 300);
    return $urandom_range(300, 4094);
  endfunction

  // Builds one random command, mostly well-formed work on known objects.
  function automatic cmd_t random_cmd(bit want_gc);
    int unsigned p, k, obj, ci;
    logic [31:0] wd;
    p = $urandom_range(0, 99);
    if (want_gc && !gc_running && p < 60) return mk(cgc_pkg::OP_START, 0, 0, 0, $urandom);
    if (gc_running && p < 30) begin
      if (from_space_objs.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, from_space_objs.size() - 1);
        return mk(cgc_pkg::OP_FORWARD, $urandom, from_space_objs[k], $urandom, $urandom);
      end
      return mk(cgc_pkg::OP_FORWARD, $urandom, ($urandom_range(0, 3) == 0) ? 0 : $urandom,
                $urandom, $urandom);
    end
    if (gc_running && p < 38)
      return mk(cgc_pkg::OP_FINISH,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40),
                $urandom, $urandom, $urandom);
    if (p < 63)
      return mk($urandom_range(0, 1) ? cgc_pkg::OP_ALLOC_INTS : cgc_pkg::OP_ALLOC_REFS,
                pick_alloc_size(), $urandom, $urandom, $urandom);
    if (p < 83 && live_objs.size() > 0) begin
      k = $urandom_range(0, live_objs.size() - 1);
      obj = live_objs[k];
      ci = (live_len[k] > 0) ? $urandom_range(0, live_len[k] - 1) : 0;
      if ($urandom_range(0, 19) == 0)
        // Corrupt the size word of the object to provoke a malformed-object fault.
        return mk(cgc_pkg::OP_WRITE, 0, cell_at(longint'(obj) + HEAP_CELLS - 2), 0,
                  $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom);
      if ($urandom_range(0, 1)) return mk(cgc_pkg::OP_READ, $urandom, obj, ci, $urandom);
      if (live_is_int[k] || live_len[k] == 0) wd = $urandom;
      else begin
        k = $urandom_range(0, 9);
        wd = (k < 6) ? live_objs[$urandom_range(0, live_objs.size() - 1)] :
             (k < 9) ? 32'd0 : $urandom;
      end
      return mk(cgc_pkg::OP_WRITE, $urandom, obj, ci, wd);
    end
    if (p < 90)
      return mk(cgc_pkg::OP_READ, $urandom, $urandom, $urandom_range(0, 4093), $urandom);
    if (p < 93)
      return mk(cgc_pkg::OP_WRITE, $urandom, $urandom, $urandom_range(0, 4093), $urandom);
    if (p < 95 && !gc_running)
      return mk(cgc_pkg::OP_FORWARD, $urandom, $urandom, $urandom, $urandom);
    if (p < 97 && !gc_running)
      return mk(cgc_pkg::OP_FINISH, $urandom, $urandom, $urandom, $urandom);
    if (p < 99 && !gc_running)
      return mk(cgc_pkg::OP_START, $urandom, $urandom, $urandom, $urandom);
    return mk(OP_NOP, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening, then random traffic, then the end of run.
  // ---------------------------------------------------------------------------
  initial begin
    bit taken, want_gc;
    int unsigned fill, a_obj, r_obj, tries;
    reply_t last;
    bump_at = 0;
    scan_at = 0;
    upper_half_active = 1'b0;
    gc_running = 1'b0;
    foreach (heap_known[i]) heap_known[i] = 1'b0;
    foreach (op_count[i]) op_count[i] = 0;

    // Directed: small objects, extreme data, echo forward, bare finish.
    offer_cmd(mk(cgc_pkg::OP_ALLOC_REFS, 0, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_ALLOC_INTS, 5, 0, 0, 0), taken);
    a_obj = owed_replies[$].result_addr;
    offer_cmd(mk(cgc_pkg::OP_ALLOC_REFS, 3, 0, 0, 0), taken);
    r_obj = owed_replies[$].result_addr;
    offer_cmd(mk(cgc_pkg::OP_WRITE, 0, r_obj, 1, a_obj), taken);
    offer_cmd(mk(cgc_pkg::OP_WRITE, 0, a_obj, 0, 32'hFFFF_FFFF), taken);
    offer_cmd(mk(cgc_pkg::OP_WRITE, 0, a_obj, 4, 32'h0), taken);
    offer_cmd(mk(cgc_pkg::OP_READ, 0, a_obj, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_READ, 0, r_obj, 1, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_FORWARD, 0, 8191, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_FINISH, 4095, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_ALLOC_INTS, 4094, 0, 0, 0), taken);
    // A collection: duplicate start, null root, the same root twice, a late alloc.
    offer_cmd(mk(cgc_pkg::OP_START, 0, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_START, 0, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_FORWARD, 0, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_FORWARD, 0, r_obj, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_FORWARD, 0, r_obj, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_ALLOC_REFS, 2, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_FINISH, 0, 0, 0, 0), taken);
    // Fill the upper half so an empty array lands in the last two heap cells.
    fill = HEAP_CELLS - 2 - bump_at - cgc_pkg::META_WORDS;
    offer_cmd(mk(cgc_pkg::OP_ALLOC_INTS, fill, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_ALLOC_REFS, 0, 0, 0, 0), taken);
    offer_cmd(mk(cgc_pkg::OP_ALLOC_REFS, 0, 0, 0, 0), taken);
    offer_cmd(mk(OP_NOP, 4095, 8191, 4095, 32'hFFFF_FFFF), taken);
    // Broken size word on a live object, then forward it during a collection.
    if (live_objs.size() > 0) begin
      offer_cmd(mk(cgc_pkg::OP_WRITE, 0, live_objs[0] - 2, 0, 1), taken);
      offer_cmd(mk(cgc_pkg::OP_START, 0, 0, 0, 0), taken);
      offer_cmd(mk(cgc_pkg::OP_FORWARD, 0, from_space_objs[0], 0, 0), taken);
      offer_cmd(mk(cgc_pkg::OP_FINISH, 0, 0, 0, 0), taken);
    end

    // Random traffic. A need-collect answer steers the next commands to a collection.
    tries = 0;
    while (total_cmds < NUM_CMDS && tries < 50 * NUM_CMDS) begin
      tries++;
      last = owed_replies[$];
      want_gc = (last.status == cgc_pkg::STAT_COLLECT) ||
                (bump_at % cgc_pkg::HALF_WORDS_DEF > 3000);
      offer_cmd(random_cmd(want_gc), taken);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_cmds.size() == 0 && owed_replies.size() == 0);
    repeat (50) @(posedge clk);
    $display("Ran %0d commands: %0d allocs, %0d forwards, %0d finishes, %0d reads, %0d writes.",
             total_cmds,
             op_count[cgc_pkg::OP_ALLOC_REFS] + op_count[cgc_pkg::OP_ALLOC_INTS],
             op_count[cgc_pkg::OP_FORWARD], op_count[cgc_pkg::OP_FINISH],
             op_count[cgc_pkg::OP_READ], op_count[cgc_pkg::OP_WRITE]);
    $display("Collections started: %0d, need-collect answers: %0d, out-of-memory answers: %0d.",
             gc_cycles_run, need_gc_seen, oom_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Command driver. Valid stays up with a steady payload until the transfer;
  // idle bursts are only inserted between commands and stop near the end.
  // ---------------------------------------------------------------------------
  int drv_gap = 0;
  always @(posedge clk) begin : cmd_driver
    bit fire;
    fire = in_valid && in_ready;
    if (rst_n) begin
      if (fire) pending_cmds.pop_front();
      if (!in_valid || fire) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          drv_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_valid <= 1'b1;
          in_op <= pending_cmds[0].op;
          in_alloc_size <= pending_cmds[0].alloc_size;
          in_ref_addr <= pending_cmds[0].ref_addr;
          in_cell_index <= pending_cmds[0].cell_index;
          in_write_data <= pending_cmds[0].write_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver. Each result transfer is checked field by field
  // against the oldest owed reply. Once, the receiver holds off for a long
  // stretch so the output register fills and the engine stops taking commands.
  // ---------------------------------------------------------------------------
  int rx_gap = 0;
  int rx_hold = 0;
  bit rx_held = 1'b0;
  always @(posedge clk) begin : result_monitor
    reply_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (owed_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d addr=%0d data=%h", $time,
                   out_status, out_result_addr, out_read_data);
        end else begin
          exp_r = owed_replies.pop_front();
          if (out_status !== exp_r.status) begin
            errors++;
            $display("%0t: op %0d status expected %0d actual %0d", $time, exp_r.op,
                     exp_r.status, out_status);
          end
          if (out_result_addr !== exp_r.result_addr) begin
            errors++;
            $display("%0t: op %0d result_addr expected %0d actual %0d", $time, exp_r.op,
                     exp_r.result_addr, out_result_addr);
          end
          if (out_read_data !== exp_r.read_data) begin
            errors++;
            $display("%0t: op %0d read_data expected %h actual %h", $time, exp_r.op,
                     exp_r.read_data, out_read_data);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!rx_held && replies_seen >= 150) begin
        rx_held = 1'b1;
        rx_hold = 400;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (replies_seen < total_cmds - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/cgc_pkg.sv
rtl/cgc_ram.sv
rtl/copying_gc_engine_top.sv
verif/copying_gc_engine_top_tb.sv
